/* sv/button_event_tracker_with_repeat_defines.svh */
// assertion macros for the button event tracker
// each macro samples on clk and is disabled while rst_n is low
`ifndef BUTTON_EVENT_TRACKER_WITH_REPEAT_DEFINES_SVH
`define BUTTON_EVENT_TRACKER_WITH_REPEAT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BET_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BET_ASSERT_IMP(lbl, ante, cons, msg)
`define BET_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/bet_pkg.sv */
`timescale 1ns / 1ps

package bet_pkg;

    localparam int BUTTONS = 32;
    localparam int IDX_W   = $clog2(BUTTONS);
    localparam int CNT_W   = $clog2(BUTTONS + 1);

    localparam logic [2:0] OP_POLL    = 3'd0;
    localparam logic [2:0] OP_BUTTON  = 3'd1;
    localparam logic [2:0] OP_HAT     = 3'd2;
    localparam logic [2:0] OP_ANALOG  = 3'd3;
    localparam logic [2:0] OP_TRIGGER = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    localparam logic [1:0] REG_DEADZONE        = 2'd0;
    localparam logic [1:0] REG_REPEAT_DELAY    = 2'd1;
    localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd2;

    localparam logic [14:0] DEADZONE_RST        = 15'h4000;
    localparam logic [15:0] REPEAT_DELAY_RST    = 16'd300;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [31:0]        now;
        logic [4:0]         button_index;
        logic               pressed;
        logic [3:0]         hat_dirs;
        logic signed [15:0] axis_value;
        logic [4:0]         neg_index;
        logic [4:0]         pos_index;
    } item_t;

    typedef struct packed {
        logic [31:0] held_mask;
        logic [31:0] pressed_now_mask;
        logic [31:0] released_now_mask;
        logic [31:0] repeated_now_mask;
    } result_t;

    // press of a button that is not held
    function automatic result_t press_btn(result_t m, logic [4:0] idx);
        result_t r;
        r = m;
        if (!m.held_mask[idx])
        begin
            r.held_mask[idx]         = 1'b1;
            r.pressed_now_mask[idx]  = 1'b1;
            r.repeated_now_mask[idx] = 1'b1;
        end
        return r;
    endfunction

    function automatic result_t release_btn(result_t m, logic [4:0] idx);
        result_t r;
        r = m;
        r.held_mask[idx]         = 1'b0;
        r.repeated_now_mask[idx] = 1'b0;
        r.released_now_mask[idx] = 1'b1;
        return r;
    endfunction

endpackage

/* sv/button_event_tracker_with_repeat.sv */
`timescale 1ns / 1ps
// button event tracker with auto-repeat
// item channel (item_valid / item_stall / item) carries one event: poll, button,
// hat, analog pair, trigger axis or clear all; result channel (result_valid /
// result_stall / result) returns the four button masks after every event
// a transfer happens at a clock edge with valid high and stall low
// button, analog, trigger, clear and unused codes update the masks at the
// transfer; a valid hat event then runs one repeat-time memory write slot per
// direction button; a poll walks the repeat-time memory one entry a cycle
// through its single read port, with the write-back of entry i in the cycle
// after its read; each result then moves into the result register once free
// the next event is taken once the masks of the current one have moved into
// the result register
// a result waiting under result_stall does not block the next event; a second
// finished result is held back until the first one is taken
// reset clears all masks and loads the register defaults; the repeat-time
// memory is not cleared, an entry's time is only used while its button is held
// and every press writes it first; config (cfg_we / cfg_index / cfg_data)
// must be written only while idle, which the block itself does not enforce
`include "button_event_tracker_with_repeat_defines.svh"

module button_event_tracker_with_repeat
    import bet_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POLL = 2'd1;
    localparam logic [1:0] ST_HAT  = 2'd2;

    // configuration
    logic [14:0] deadzone_reg;
    logic [15:0] repeat_delay_reg;
    logic [15:0] repeat_interval_reg;

    // control
    logic [1:0]       state_reg, state_next;
    logic             pend_reg, pend_next;
    logic             result_valid_reg, result_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [1:0]       hat_cnt_reg, hat_cnt_next;

    // masks and payload
    result_t     masks_reg, masks_next;
    result_t     result_reg, result_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] arm_time_reg, arm_time_next;
    logic [3:0]  arm_reg, arm_next;

    // repeat-time memory
    logic [31:0]      rtime_mem [BUTTONS];
    logic [31:0]      rdata_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;

    logic               accept;
    logic               result_load;
    logic signed [16:0] val_x;
    logic signed [16:0] dz_pos;
    logic signed [16:0] dz_neg;
    logic               val_pos;
    logic [31:0]        press_time;
    logic [31:0]        due_diff;
    logic               poll_hit;
    logic               poll_last;

    assign item_stall   = !(state_reg == ST_IDLE && !pend_reg);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // analog thresholds in 17-bit signed
    assign val_x   = {item.axis_value[15], item.axis_value};
    assign dz_pos  = $signed({2'b00, deadzone_reg});
    assign dz_neg  = -dz_pos;
    assign val_pos = !item.axis_value[15] && (|item.axis_value);

    assign press_time = item.now + {16'b0, repeat_delay_reg};

    // poll compare, wrap-aware: due when now - time is below 2^31
    assign due_diff  = now_reg - rdata_reg;
    assign poll_hit  = (state_reg == ST_POLL) && rd_vld_reg && !due_diff[31]
                       && masks_reg.held_mask[rd_idx_reg];
    assign poll_last = rd_vld_reg && (rd_idx_reg == IDX_W'(BUTTONS - 1));

    // memory read side: one entry a cycle during a poll
    assign rd_en   = (state_reg == ST_POLL) && (cnt_reg < CNT_W'(BUTTONS));
    assign rd_addr = cnt_reg[IDX_W-1:0];

    // a finished result moves into the output register once it is free
    assign result_load = pend_reg && (!result_valid_reg || !result_stall);

    always_comb
    begin
        result_t m;
        m                 = masks_reg;
        state_next        = state_reg;
        pend_next         = pend_reg;
        cnt_next          = cnt_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_idx_reg;
        hat_cnt_next      = hat_cnt_reg;
        now_next          = now_reg;
        arm_time_next     = arm_time_reg;
        arm_next          = arm_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        wr_en             = 1'b0;
        wr_addr           = item.button_index;
        wr_data           = press_time;

        if (accept)
        begin
            pend_next = 1'b1;
            case (item.opcode)
                OP_POLL:
                begin
                    m.pressed_now_mask  = '0;
                    m.released_now_mask = '0;
                    m.repeated_now_mask = '0;
                    now_next            = item.now;
                    cnt_next            = '0;
                    pend_next           = 1'b0;
                    state_next          = ST_POLL;
                end
                OP_BUTTON:
                begin
                    if (item.pressed)
                    begin
                        wr_en = !masks_reg.held_mask[item.button_index];
                        m     = press_btn(m, item.button_index);
                    end
                    else
                    begin
                        m = release_btn(m, item.button_index);
                    end
                end
                OP_HAT:
                begin
                    // contradictory directions change nothing
                    if (!((item.hat_dirs[0] && item.hat_dirs[1]) ||
                          (item.hat_dirs[2] && item.hat_dirs[3])))
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            if (item.hat_dirs[i])
                                m = press_btn(m, 5'(i));
                            else
                                m = release_btn(m, 5'(i));
                        end
                        arm_next      = item.hat_dirs & ~masks_reg.held_mask[3:0];
                        arm_time_next = press_time;
                        hat_cnt_next  = '0;
                        pend_next     = 1'b0;
                        state_next    = ST_HAT;
                    end
                end
                OP_ANALOG:
                begin
                    if (val_x > dz_pos)
                    begin
                        wr_addr = item.pos_index;
                        if (!m.held_mask[item.pos_index])
                        begin
                            wr_en = 1'b1;
                            m     = press_btn(m, item.pos_index);
                            if (m.held_mask[item.neg_index])
                                m = release_btn(m, item.neg_index);
                        end
                    end
                    else if (val_x < dz_neg)
                    begin
                        wr_addr = item.neg_index;
                        if (!m.held_mask[item.neg_index])
                        begin
                            wr_en = 1'b1;
                            m     = press_btn(m, item.neg_index);
                            if (m.held_mask[item.pos_index])
                                m = release_btn(m, item.pos_index);
                        end
                    end
                    else
                    begin
                        if (m.held_mask[item.neg_index])
                            m = release_btn(m, item.neg_index);
                        if (m.held_mask[item.pos_index])
                            m = release_btn(m, item.pos_index);
                    end
                end
                OP_TRIGGER:
                begin
                    if (val_pos)
                    begin
                        wr_en = !masks_reg.held_mask[item.button_index];
                        m     = press_btn(m, item.button_index);
                    end
                    else if (m.held_mask[item.button_index])
                    begin
                        m = release_btn(m, item.button_index);
                    end
                end
                OP_CLEAR:
                begin
                    m = '0;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_POLL:
            begin
                if (rd_en)
                    cnt_next = cnt_reg + CNT_W'(1);
                rd_vld_next = rd_en;
                rd_idx_next = rd_addr;
                // write-back comes in the cycle after the read of the same entry
                if (poll_hit)
                begin
                    m.repeated_now_mask[rd_idx_reg] = 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg;
                    wr_data = rdata_reg + {16'b0, repeat_interval_reg};
                end
                if (poll_last)
                begin
                    pend_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_HAT:
            begin
                wr_en        = arm_reg[hat_cnt_reg];
                wr_addr      = IDX_W'(hat_cnt_reg);
                wr_data      = arm_time_reg;
                hat_cnt_next = hat_cnt_reg + 2'd1;
                if (hat_cnt_reg == 2'd3)
                begin
                    pend_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        if (result_load)
        begin
            result_next       = masks_reg;
            result_valid_next = 1'b1;
            pend_next         = 1'b0;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        masks_next = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg        <= DEADZONE_RST;
            repeat_delay_reg    <= REPEAT_DELAY_RST;
            repeat_interval_reg <= REPEAT_INTERVAL_RST;
            state_reg           <= ST_IDLE;
            pend_reg            <= 1'b0;
            result_valid_reg    <= 1'b0;
            cnt_reg             <= '0;
            rd_vld_reg          <= 1'b0;
            rd_idx_reg          <= '0;
            hat_cnt_reg         <= '0;
            masks_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEADZONE:        deadzone_reg        <= cfg_data[14:0];
                    REG_REPEAT_DELAY:    repeat_delay_reg    <= cfg_data;
                    REG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            cnt_reg          <= cnt_next;
            rd_vld_reg       <= rd_vld_next;
            rd_idx_reg       <= rd_idx_next;
            hat_cnt_reg      <= hat_cnt_next;
            masks_reg        <= masks_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        arm_time_reg <= arm_time_next;
        arm_reg      <= arm_next;
        result_reg   <= result_next;
    end

    // repeat-time memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rtime_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= rtime_mem[rd_addr];
    end

    // a repeat flag only stands for a held button
    `BET_ASSERT_IMP(a_repeat_held, 1'b1,
        (masks_reg.repeated_now_mask & ~masks_reg.held_mask) == 32'b0,
        "repeat flag set for a button that is not held")
    // memory writes only come from an event transfer or a running sequence
    `BET_ASSERT_IMP(a_write_src, wr_en, accept || state_reg != ST_IDLE,
        "repeat-time write while idle")
    // the last poll entry finishes the poll with a result pending
    `BET_ASSERT_NXT(a_poll_done, state_reg == ST_POLL && poll_last,
        state_reg == ST_IDLE && (pend_reg || result_valid_reg),
        "poll did not finish after the last entry")
    // no new transfer while a finished result is still held back
    `BET_ASSERT_IMP(a_no_overrun, pend_reg && result_valid_reg && result_stall,
        !accept, "event taken while a result is held back")

endmodule

/* sim/tb_button_event_tracker_with_repeat.sv */
`timescale 1ns / 1ps

module tb_button_event_tracker_with_repeat;
    import bet_pkg::*;

    // opcodes the block does not decode, they must leave the masks alone
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam int DIR_ROWS       = 24;
    localparam int PHASES         = 4;
    localparam int PHASE_ITEMS    = 310;
    localparam int CALM_ITEMS     = 150;
    localparam int LONG_HOLD      = 80;
    // a poll is the slowest event, give it some margin before a register write
    localparam int SETTLE_CYCLES  = BUTTONS + 8;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // tracker state as the predictor sees it
    logic [31:0] trk_held = '0;
    logic [31:0] trk_down = '0;
    logic [31:0] trk_up   = '0;
    logic [31:0] trk_rep  = '0;
    logic [31:0] trk_due [BUTTONS];
    logic [14:0] dz_cfg    = DEADZONE_RST;
    logic [15:0] delay_cfg = REPEAT_DELAY_RST;
    logic [15:0] ivl_cfg   = REPEAT_INTERVAL_RST;

    // masks still owed by the block, oldest first
    result_t pending_masks [$];

    dir_row_t dir_rows [DIR_ROWS];
    logic [31:0] clock_now = '0;
    int fail_count = 0;

    // receiver side pattern
    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int rx_left   = 0;
    bit rx_stall  = 1'b0;
    int idle_cycles = 0;

    logic [127:0] want_bits;
    logic [127:0] got_bits;
    int f;
    string mask_names [4] = '{"held_mask", "pressed_now_mask", "released_now_mask",
                              "repeated_now_mask"};

    button_event_tracker_with_repeat i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // first press arms the repeat time, a press of a held button does nothing
    function automatic void mark_down(input logic [4:0] b, input logic [31:0] t);
        if (!trk_held[b])
        begin
            trk_held[b] = 1'b1;
            trk_down[b] = 1'b1;
            trk_rep[b]  = 1'b1;
            trk_due[b]  = t + delay_cfg;
        end
    endfunction

    // release is unconditional here, callers filter where needed
    function automatic void mark_up(input logic [4:0] b);
        trk_held[b] = 1'b0;
        trk_rep[b]  = 1'b0;
        trk_up[b]   = 1'b1;
    endfunction

    // one side of the analog pair wins: press it, drop the opposite one if held;
    // with on == off the press is undone right away
    function automatic void pair_swing(input logic [4:0] on, input logic [4:0] off,
                                       input logic [31:0] t);
        if (!trk_held[on])
        begin
            mark_down(on, t);
            if (trk_held[off])
                mark_up(off);
        end
    endfunction

    function automatic result_t track_event(input item_t it);
        int v;
        int dz_i;
        logic [31:0] lag;
        v    = $signed(it.axis_value);
        dz_i = dz_cfg;
        case (it.opcode)
            OP_POLL:
            begin
                trk_down = '0;
                trk_up   = '0;
                trk_rep  = '0;
                for (int b = 0; b < BUTTONS; b++)
                begin
                    // wrap-aware: due once now has reached the repeat time
                    lag = it.now - trk_due[b];
                    if (trk_held[b] && !lag[31])
                    begin
                        trk_rep[b] = 1'b1;
                        trk_due[b] = trk_due[b] + ivl_cfg;
                    end
                end
            end
            OP_BUTTON:
            begin
                if (it.pressed)
                    mark_down(it.button_index, it.now);
                else
                    mark_up(it.button_index);
            end
            OP_HAT:
            begin
                // up with down or left with right is contradictory, ignored
                if (!(it.hat_dirs[0] && it.hat_dirs[1]) && !(it.hat_dirs[2] && it.hat_dirs[3]))
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        if (it.hat_dirs[b])
                            mark_down(b[4:0], it.now);
                        else
                            mark_up(b[4:0]);
                    end
                end
            end
            OP_ANALOG:
            begin
                if (v > dz_i)
                    pair_swing(it.pos_index, it.neg_index, it.now);
                else if (v < -dz_i)
                    pair_swing(it.neg_index, it.pos_index, it.now);
                else
                begin
                    if (trk_held[it.neg_index])
                        mark_up(it.neg_index);
                    if (trk_held[it.pos_index])
                        mark_up(it.pos_index);
                end
            end
            OP_TRIGGER:
            begin
                if (v > 0)
                    mark_down(it.button_index, it.now);
                else if (trk_held[it.button_index])
                    mark_up(it.button_index);
            end
            OP_CLEAR:
            begin
                trk_held = '0;
                trk_down = '0;
                trk_up   = '0;
                trk_rep  = '0;
            end
            default:
            begin
            end
        endcase
        return '{trk_held, trk_down, trk_up, trk_rep};
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t ev(input logic [2:0] op, input logic [31:0] t,
                                 input logic [4:0] idx, input logic prs,
                                 input logic [3:0] hat, input logic [15:0] val,
                                 input logic [4:0] neg, input logic [4:0] pos);
        item_t it;
        it.opcode       = op;
        it.now          = t;
        it.button_index = idx;
        it.pressed      = prs;
        it.hat_dirs     = hat;
        it.axis_value   = val;
        it.neg_index    = neg;
        it.pos_index    = pos;
        return it;
    endfunction

    // random event on a time base that mostly moves forward, so polls catch repeats
    function automatic item_t next_event();
        item_t it;
        logic [95:0] raw;
        int unsigned pick;
        int unsigned span;
        int mag;
        raw  = {$urandom, $urandom, $urandom};
        it   = raw[$bits(item_t)-1:0];
        span = delay_cfg / 4 + ivl_cfg / 2 + 8;
        if ($urandom_range(0, 49) == 0)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(0, span);
        it.now = clock_now;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            it.opcode = OP_POLL;
        else if (pick < 55)
            it.opcode = OP_BUTTON;
        else if (pick < 65)
            it.opcode = OP_HAT;
        else if (pick < 80)
            it.opcode = OP_ANALOG;
        else if (pick < 92)
            it.opcode = OP_TRIGGER;
        else if (pick < 95)
            it.opcode = OP_CLEAR;
        else
            it.opcode = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;

        if (it.opcode == OP_ANALOG)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    // just below, at and just above the deadzone edge
                    mag = dz_cfg;
                    mag = mag - 1 + int'($urandom_range(0, 2));
                    if ($urandom_range(0, 1))
                        mag = -mag;
                    if (mag > 32767)
                        mag = 32767;
                    if (mag < -32768)
                        mag = -32768;
                    it.axis_value = mag[15:0];
                end
                1: it.axis_value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default:
                begin
                end
            endcase
            if ($urandom_range(0, 7) == 0)
                it.pos_index = it.neg_index;
        end
        else if (it.opcode == OP_TRIGGER)
        begin
            case ($urandom_range(0, 5))
                0: it.axis_value = 16'h0000;
                1: it.axis_value = 16'h0001;
                2: it.axis_value = 16'hFFFF;
                default:
                begin
                end
            endcase
        end
        return it;
    endfunction

    // offer one item and hold it until the transfer
    task automatic send_item(input item_t it);
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // random sender gaps after a transfer, none in the calm tail
    int free_run = 0;
    task automatic pace();
        int gap;
        if (calm)
            return;
        if (free_run > 0)
        begin
            free_run--;
            return;
        end
        if ($urandom_range(0, 19) == 0)
            free_run = $urandom_range(20, 40);
        else if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering until every owed result is in, optionally let the block go idle
    task automatic settle(input bit with_tail);
        item_valid <= 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        if (with_tail)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] dz_word, input logic [15:0] dly,
                              input logic [15:0] ivl);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEADZONE;
        cfg_data  <= dz_word;
        @(posedge clk);
        cfg_index <= REG_REPEAT_DELAY;
        cfg_data  <= dly;
        @(posedge clk);
        cfg_index <= REG_REPEAT_INTERVAL;
        cfg_data  <= ivl;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // deadzone keeps only its low 15 bits
        dz_cfg    = dz_word[14:0];
        delay_cfg = dly;
        ivl_cfg   = ivl;
    endtask

    // ------------------------------------------------------------------
    // result side: checks every transfer and drives the stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_masks.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, result);
                    fail_count++;
                end
                else
                begin
                    want_bits = pending_masks.pop_front();
                    got_bits  = result;
                    for (f = 0; f < 4; f++)
                    begin
                        if (got_bits[127 - 32 * f -: 32] !== want_bits[127 - 32 * f -: 32])
                        begin
                            $display("%0t: %s mismatch, expected %08h, actual %08h",
                                     $time, mask_names[f],
                                     want_bits[127 - 32 * f -: 32],
                                     got_bits[127 - 32 * f -: 32]);
                            fail_count++;
                        end
                    end
                end
            end

            // long hold-off so the block fills up and stalls its input
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (calm)
                result_stall <= 1'b0;
            else
            begin
                // random stall bursts and run bursts, and now and then a long clean run
                if (rx_left == 0)
                begin
                    rx_stall = ($urandom_range(0, 2) == 0);
                    if (rx_stall)
                        rx_left = $urandom_range(1, 9);
                    else if ($urandom_range(0, 5) == 0)
                        rx_left = $urandom_range(20, 50);
                    else
                        rx_left = $urandom_range(1, 9);
                end
                rx_left--;
                result_stall <= rx_stall;
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_t   it;
        result_t predicted;

        // directed rows, default registers: delay 300, interval 100, deadzone 0x4000
        // unused code straight after reset shows empty masks
        dir_rows[0]  = '{ev(OP_UNUSED_6, 32'd0, 5'd0, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b1, '{32'h0, 32'h0, 32'h0, 32'h0}};
        // top button, repeat time 300
        dir_rows[1]  = '{ev(OP_BUTTON, 32'd0, 5'd31, 1'b1, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b1, '{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000}};
        // button 0 just before the time wrap, repeat time lands at 0x2c
        dir_rows[2]  = '{ev(OP_BUTTON, 32'hFFFF_FF00, 5'd0, 1'b1, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b1, '{32'h8000_0001, 32'h8000_0001, 32'h0, 32'h8000_0001}};
        // poll at the last tick before the wrap: nothing due yet
        dir_rows[3]  = '{ev(OP_POLL, 32'hFFFF_FFFF, 5'd0, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b1, '{32'h8000_0001, 32'h0, 32'h0, 32'h0}};
        // exactly at button 0's repeat time across the wrap
        dir_rows[4]  = '{ev(OP_POLL, 32'h0000_002C, 5'd0, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b1, '{32'h8000_0001, 32'h0, 32'h0, 32'h0000_0001}};
        // both due: button 31 at its first repeat, button 0 past its second
        dir_rows[5]  = '{ev(OP_POLL, 32'h0000_012C, 5'd0, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b1, '{32'h8000_0001, 32'h0, 32'h0, 32'h8000_0001}};
        // press of a held button, release of one not held, release of a held one
        dir_rows[6]  = '{ev(OP_BUTTON, 32'h0000_0130, 5'd31, 1'b1, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b0, '0};
        dir_rows[7]  = '{ev(OP_BUTTON, 32'h0000_0131, 5'd5, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b0, '0};
        dir_rows[8]  = '{ev(OP_BUTTON, 32'h0000_0132, 5'd31, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b0, '0};
        // contradictory hats, then a diagonal, then centred
        dir_rows[9]  = '{ev(OP_HAT, 32'h0000_0140, 5'd0, 1'b0, 4'h3, 16'h0, 5'd0, 5'd0),
                         1'b0, '0};
        dir_rows[10] = '{ev(OP_HAT, 32'h0000_0141, 5'd0, 1'b0, 4'hC, 16'h0, 5'd0, 5'd0),
                         1'b0, '0};
        dir_rows[11] = '{ev(OP_HAT, 32'h0000_0142, 5'd0, 1'b0, 4'h9, 16'h0, 5'd0, 5'd0),
                         1'b0, '0};
        dir_rows[12] = '{ev(OP_HAT, 32'h0000_0143, 5'd0, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b0, '0};
        // analog pair: full positive, full negative, exactly at the deadzone
        dir_rows[13] = '{ev(OP_ANALOG, 32'h0000_0150, 5'd0, 1'b0, 4'h0, 16'h7FFF, 5'd7, 5'd8),
                         1'b0, '0};
        dir_rows[14] = '{ev(OP_ANALOG, 32'h0000_0151, 5'd0, 1'b0, 4'h0, 16'h8000, 5'd7, 5'd8),
                         1'b0, '0};
        dir_rows[15] = '{ev(OP_ANALOG, 32'h0000_0152, 5'd0, 1'b0, 4'h0, 16'h4000, 5'd7, 5'd8),
                         1'b0, '0};
        // same button on both sides of the pair, then a distinct pair just past the negative edge
        dir_rows[16] = '{ev(OP_ANALOG, 32'h0000_0153, 5'd0, 1'b0, 4'h0, 16'h4001, 5'd9, 5'd9),
                         1'b0, '0};
        dir_rows[17] = '{ev(OP_ANALOG, 32'h0000_0154, 5'd0, 1'b0, 4'h0, 16'hBFFF, 5'd10, 5'd11),
                         1'b0, '0};
        // trigger: press, release of an unheld button ignored, release at full negative
        dir_rows[18] = '{ev(OP_TRIGGER, 32'h0000_0160, 5'd20, 1'b0, 4'h0, 16'h0001, 5'd0, 5'd0),
                         1'b0, '0};
        dir_rows[19] = '{ev(OP_TRIGGER, 32'h0000_0161, 5'd21, 1'b0, 4'h0, 16'h0000, 5'd0, 5'd0),
                         1'b0, '0};
        dir_rows[20] = '{ev(OP_TRIGGER, 32'h0000_0162, 5'd20, 1'b0, 4'h0, 16'h8000, 5'd0, 5'd0),
                         1'b0, '0};
        dir_rows[21] = '{ev(OP_UNUSED_7, 32'h0000_0163, 5'd0, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b0, '0};
        // clear all, then a poll finds nothing held
        dir_rows[22] = '{ev(OP_CLEAR, 32'h0000_0170, 5'd0, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b1, '{32'h0, 32'h0, 32'h0, 32'h0}};
        dir_rows[23] = '{ev(OP_POLL, 32'h1234_5678, 5'd0, 1'b0, 4'h0, 16'h0, 5'd0, 5'd0),
                         1'b1, '{32'h0, 32'h0, 32'h0, 32'h0}};

        for (int b = 0; b < BUTTONS; b++)
            trk_due[b] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int n = 0; n < DIR_ROWS; n++)
        begin
            send_item(dir_rows[n].it);
            predicted = track_event(dir_rows[n].it);
            pending_masks.push_back(dir_rows[n].typed ? dir_rows[n].want : predicted);
            pace();
        end

        // random part, one register setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle(1'b1);
                case (phase)
                    // fastest repeats, any nonzero sample counts
                    1: write_regs({1'($urandom_range(0, 1)), 15'h0000}, 16'd0, 16'd1);
                    // widest deadzone, slowest repeats
                    2: write_regs({1'($urandom_range(0, 1)), 15'h7FFF}, 16'hFFFF, 16'hFFFF);
                    default: write_regs(16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 3000)),
                                        16'($urandom_range(1, 800)));
                endcase
            end
            // the slow phase starts just before the time wrap
            if (phase == 2)
                clock_now = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == PHASES - 1 && n == PHASE_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                // sender waits for every owed result once
                if (phase == 0 && n == 150)
                    settle(1'b0);
                // receiver holds off while the sender keeps offering
                if (phase == 1 && n == 100)
                    hold_req = 1'b1;
                it = next_event();
                send_item(it);
                pending_masks.push_back(track_event(it));
                pace();
            end
        end

        settle(1'b1);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/bet_pkg.sv
sv/button_event_tracker_with_repeat.sv
sim/tb_button_event_tracker_with_repeat.sv
